// ===== hw/rtl/tds_pkg.sv =====
// shared widths, types and defaults for the tagged descending sorter
`timescale 1ns / 1ps

package tds_pkg;

   localparam int KEY_W        = 32;
   localparam int TAG_W        = 6;
   localparam int DATA_W       = 40;
   localparam int CAPACITY_DEF = 64;

   typedef struct packed {
      logic [TAG_W-1:0] tag;
      logic [KEY_W-1:0] key;
   } entry_type;

   typedef struct packed {
      logic insert;
      logic pop;
   } cell_ctrl_type;

endpackage

// ===== hw/rtl/tds_cell.sv =====
// one cell of the sorting chain: holds one entry, shifts down on insert and up on pop
`timescale 1ns / 1ps

module tds_cell
   import tds_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  entry_type     new_entry,
   input  entry_type     prev_entry,
   input  logic          prev_take,
   input  logic          prev_valid,
   input  entry_type     next_entry,
   input  logic          next_valid,
   output entry_type     entry,
   output logic          valid,
   output logic          take
);

   entry_type entry_ff;
   entry_type entry_in;
   logic      valid_ff;
   logic      valid_in;

   // empty cells rank below everything; equal keys stay put
   assign take  = !valid_ff || (new_entry.key > entry_ff.key);
   assign entry = entry_ff;
   assign valid = valid_ff;

   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      if (ctrl.pop) begin
         entry_in = next_entry;
         valid_in = next_valid;
      end else if (ctrl.insert && take) begin
         entry_in = prev_take ? prev_entry : new_entry;
         valid_in = valid_ff || prev_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ===== hw/rtl/tagged_descending_sorter.sv =====
// top level of the tagged descending sorter: cell chain, drain control and result register
//
// req channel: one (score, tag) entry per transfer; req_tlast marks the final entry of a set.
// Each accepted entry is inserted into a chain of CAPACITY cells, the chain
// staying sorted by descending score with equal scores in arrival order. Entries that
// arrive while every cell is full are dropped and the set is flagged.
// After the final entry the block drains: the chain shifts towards its head one entry per
// cycle into the rsp register. rsp_tlast marks the lowest-ranked result and rsp_tuser
// carries the overflow flag on every result of the set.
// The final entry's transfer moves the block into its drain state; each pop then loads the rsp register.
// Throughput: one entry per cycle while filling, one result per cycle while draining and rsp_tready
// allows; req_tready is low for the whole drain.
// A stalled rsp_tready holds the result register and freezes the chain.
// Reset empties every cell, clears the overflow flag and the result register's valid bit.

`timescale 1ns / 1ps

module tagged_descending_sorter
   import tds_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [DATA_W-1:0] req_tdata,  // score_key[31:0], entry_tag[37:32], zero[39:38]
   input  logic              req_tlast,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [DATA_W-1:0] rsp_tdata,  // sorted_key[31:0], sorted_tag[37:32], zero[39:38]
   output logic              rsp_tlast,
   output logic              rsp_tuser   // overflow[0]
);

   localparam logic ST_FILL  = 1'b0;
   localparam logic ST_DRAIN = 1'b1;

   logic          state_ff;
   logic          state_in;
   logic          dropped_ff;
   logic          dropped_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   entry_type     rsp_entry_ff;
   entry_type     rsp_entry_in;
   logic          rsp_last_ff;
   logic          rsp_last_in;
   logic          rsp_ovf_ff;
   logic          rsp_ovf_in;

   entry_type     new_entry;
   entry_type     cell_entry [CAPACITY];
   logic          cell_valid [CAPACITY];
   logic          cell_take  [CAPACITY];
   cell_ctrl_type ctrl;
   logic          req_xfer;
   logic          full;
   logic          pop;
   logic          pop_last;

   assign new_entry.key = req_tdata[KEY_W-1:0];
   assign new_entry.tag = req_tdata[KEY_W+TAG_W-1:KEY_W];

   assign req_tready = (state_ff == ST_FILL);
   assign req_xfer   = req_tvalid && req_tready;
   assign full       = cell_valid[CAPACITY-1];
   assign pop        = (state_ff == ST_DRAIN) && (!rsp_valid_ff || rsp_tready);
   assign pop_last   = !cell_valid[1];

   assign ctrl.insert = req_xfer && !full;
   assign ctrl.pop    = pop;

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         entry_type prev_entry;
         logic      prev_take;
         logic      prev_valid;
         entry_type next_entry;
         logic      next_valid;

         if (gi == 0) begin : g_head
            assign prev_entry = new_entry;
            assign prev_take  = 1'b0;
            assign prev_valid = 1'b1;
         end else begin : g_body
            assign prev_entry = cell_entry[gi-1];
            assign prev_take  = cell_take[gi-1];
            assign prev_valid = cell_valid[gi-1];
         end

         if (gi == CAPACITY - 1) begin : g_tail
            assign next_entry = cell_entry[gi];
            assign next_valid = 1'b0;
         end else begin : g_inner
            assign next_entry = cell_entry[gi+1];
            assign next_valid = cell_valid[gi+1];
         end

         tds_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .new_entry  (new_entry),
            .prev_entry (prev_entry),
            .prev_take  (prev_take),
            .prev_valid (prev_valid),
            .next_entry (next_entry),
            .next_valid (next_valid),
            .entry      (cell_entry[gi]),
            .valid      (cell_valid[gi]),
            .take       (cell_take[gi])
         );
      end
   endgenerate

   always_comb begin
      state_in     = state_ff;
      dropped_in   = dropped_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_entry_in = rsp_entry_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_FILL: begin
            if (req_xfer) begin
               if (full) begin
                  dropped_in = 1'b1;
               end
               if (req_tlast) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (pop) begin
               rsp_valid_in = 1'b1;
               rsp_entry_in = cell_entry[0];
               rsp_last_in  = pop_last;
               rsp_ovf_in   = dropped_ff;
               if (pop_last) begin
                  state_in   = ST_FILL;
                  dropped_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_FILL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_entry_ff <= rsp_entry_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(DATA_W-KEY_W-TAG_W){1'b0}}, rsp_entry_ff.tag, rsp_entry_ff.key};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_ovf_ff;

endmodule

// ===== tb/sv/testbench.sv =====
// self-checking testbench for the tagged descending sorter
`timescale 1ns / 1ps

module testbench;
   import tds_pkg::*;

   localparam int SLOTS       = CAPACITY_DEF;
   localparam int QUIET_LIMIT = 3000;
   localparam int HOLD_CYCLES = 400;
   localparam int ITEM_TARGET = 480;
   localparam int GAP_PERCENT = 34;

   typedef struct {
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] tag;
      logic             last;
   } score_entry_type;

   typedef struct {
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] tag;
      logic             run_end;
      logic             overflow;
   } ranked_result_type;

   logic              clock;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [DATA_W-1:0] req_tdata  = '0;  // score_key[31:0], entry_tag[37:32], zero[39:38]
   logic              req_tlast  = 1'b0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [DATA_W-1:0] rsp_tdata;        // sorted_key[31:0], sorted_tag[37:32], zero[39:38]
   logic              rsp_tlast;
   logic              rsp_tuser;        // overflow[0]

   tagged_descending_sorter i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   score_entry_type   pending_entries[$];
   ranked_result_type ranked_q[$];
   score_entry_type   entry_on_bus;
   ranked_result_type want;

   logic [KEY_W-1:0] held_key[SLOTS];
   logic [TAG_W-1:0] held_tag[SLOTS];
   int               held_count   = 0;
   bit               held_dropped = 1'b0;

   int sent_count = 0;
   int rx_count   = 0;
   int hold_left  = 0;
   bit hold_done  = 1'b0;
   int quiet      = 0;
   bit failed     = 1'b0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // insertion keeps ties in arrival order; a final entry releases the whole set
   task automatic keep_score(input score_entry_type e);
      int                pos;
      ranked_result_type r;
      if (held_count < SLOTS) begin
         pos = held_count;
         while (pos > 0 && e.key > held_key[pos-1]) begin
            held_key[pos] = held_key[pos-1];
            held_tag[pos] = held_tag[pos-1];
            pos--;
         end
         held_key[pos] = e.key;
         held_tag[pos] = e.tag;
         held_count++;
      end else begin
         held_dropped = 1'b1;
      end
      if (e.last) begin
         for (int k = 0; k < held_count; k++) begin
            r.key      = held_key[k];
            r.tag      = held_tag[k];
            r.run_end  = (k == held_count - 1);
            r.overflow = held_dropped;
            ranked_q.push_back(r);
         end
         held_count   = 0;
         held_dropped = 1'b0;
      end
   endtask

   task automatic add_entry(input logic [KEY_W-1:0] key, input logic [TAG_W-1:0] tag,
                            input logic last);
      score_entry_type e;
      e.key  = key;
      e.tag  = tag;
      e.last = last;
      pending_entries.push_back(e);
   endtask

   function automatic logic [KEY_W-1:0] pick_key(input int flavour);
      logic [KEY_W-1:0] k;
      case (flavour)
         0: k = $urandom;
         1: k = $urandom_range(0, 7);
         2: begin
            case ($urandom_range(0, 2))
               0: k = '0;
               1: k = '1;
               default: k = $urandom;
            endcase
         end
         default: k = {4'hF, 28'($urandom_range(0, 15))};
      endcase
      return k;
   endfunction

   task automatic add_random_set(input int size);
      int flavour;
      flavour = $urandom_range(0, 3);
      for (int i = 0; i < size; i++)
         add_entry(pick_key(flavour), TAG_W'($urandom_range(0, 63)), i == size - 1);
   endtask

   // stimulus
   initial begin
      int set_index;
      int size;
      // single entry sets at both extremes
      add_entry('1, 6'd63, 1'b1);
      add_entry('0, 6'd0, 1'b1);
      // ties and extremes mixed
      add_entry(32'd5, 6'd1, 1'b0);
      add_entry('0, 6'd2, 1'b0);
      add_entry('1, 6'd3, 1'b0);
      add_entry(32'd5, 6'd4, 1'b0);
      add_entry(32'd5, 6'd5, 1'b0);
      add_entry(32'd7, 6'd6, 1'b0);
      add_entry('0, 6'd7, 1'b0);
      add_entry('1, 6'd8, 1'b1);
      // ascending arrival: every entry moves to the head
      for (int i = 0; i < 6; i++)
         add_entry(KEY_W'(i + 1), TAG_W'(10 + i), i == 5);
      // descending arrival: already in order
      for (int i = 0; i < 6; i++)
         add_entry(KEY_W'(6 - i), TAG_W'(20 + i), i == 5);

      set_index = 0;
      while (pending_entries.size() < ITEM_TARGET) begin
         if (set_index == 0)
            size = SLOTS;            // exactly full, no drop
         else if (set_index == 1)
            size = SLOTS + 2;        // drops, final entry meets a full store
         else if ($urandom_range(0, 9) == 0)
            size = $urandom_range(SLOTS - 1, SLOTS + 8);
         else
            size = $urandom_range(1, 12);
         add_random_set(size);
         set_index++;
      end
   end

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tlast  <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            keep_score(entry_on_bus);
            sent_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_entries.size() > 0 &&
                ((sent_count >= 200 && sent_count < 320) ||
                 $urandom_range(0, 99) >= GAP_PERCENT)) begin
               entry_on_bus = pending_entries.pop_front();
               req_tvalid  <= 1'b1;
               req_tdata   <= {2'b00, entry_on_bus.tag, entry_on_bus.key};
               req_tlast   <= entry_on_bus.last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver and checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rx_count++;
            if (ranked_q.size() == 0) begin
               $error("result with nothing expected: key %h tag %0d", rsp_tdata[31:0],
                      rsp_tdata[37:32]);
               failed = 1'b1;
            end else begin
               want = ranked_q.pop_front();
               if (rsp_tdata[31:0] !== want.key) begin
                  $error("sorted_key: expected %h, got %h", want.key, rsp_tdata[31:0]);
                  failed = 1'b1;
               end
               if (rsp_tdata[37:32] !== want.tag) begin
                  $error("sorted_tag: expected %0d, got %0d", want.tag, rsp_tdata[37:32]);
                  failed = 1'b1;
               end
               if (rsp_tlast !== want.run_end) begin
                  $error("run_end: expected %b, got %b", want.run_end, rsp_tlast);
                  failed = 1'b1;
               end
               if (rsp_tuser !== want.overflow) begin
                  $error("overflow: expected %b, got %b", want.overflow, rsp_tuser);
                  failed = 1'b1;
               end
            end
         end
         // one long hold-off mid drain so the block backs up into its input
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!hold_done && rx_count >= 150 && rsp_tvalid) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= (rx_count >= 250 && rx_count < 350) ||
                          ($urandom_range(0, 99) >= GAP_PERCENT);
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      do
         @(posedge clock);
      while (pending_entries.size() != 0 || req_tvalid || ranked_q.size() != 0);
      repeat (20) @(posedge clock);
      if (!failed && ranked_q.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/tds_pkg.sv
hw/rtl/tds_cell.sv
hw/rtl/tagged_descending_sorter.sv
tb/sv/testbench.sv
